// ===== hw/rtl/mra_pkg.sv =====
// Package for the multichannel running average core.
// Field widths, queue entry type, back-end state codes, APB register map.
// No dependencies.
package mra_pkg;

  localparam int unsigned ChanW       = 4;
  localparam int unsigned SampleW     = 10;
  localparam int unsigned AvgW        = 10;
  localparam int unsigned CntW        = 10;
  localparam int unsigned SumW        = 21;
  localparam int unsigned DefChannels = 9;

  localparam int unsigned DivSteps = SumW;
  localparam int unsigned StepW    = $clog2(DivSteps + 1);

  localparam logic [CntW-1:0] LimitReset = CntW'(16);

  localparam int unsigned PAddrW = 3;
  localparam int unsigned PDataW = 32;

  typedef enum logic [0:0] {
    RegWindowLimit = 1'b0
  } reg_idx_e;

  typedef struct packed {
    logic [ChanW-1:0]   channel;
    logic [SampleW-1:0] sample;
    logic               in_range;
  } item_t;

  typedef enum logic [1:0] {
    StIdle,
    StLoad,
    StDiv,
    StDone
  } back_state_e;

endpackage

// ===== hw/rtl/mra_if.sv =====
// Request and result channel interfaces of the running average core.
// Depends on mra_pkg.
interface mra_req_if;
  import mra_pkg::*;

  logic               valid;
  logic               ready;
  logic [ChanW-1:0]   channel;
  logic [SampleW-1:0] sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface mra_res_if;
  import mra_pkg::*;

  logic             valid;
  logic             ready;
  logic [ChanW-1:0] out_channel;
  logic [AvgW-1:0]  average;

  modport source (output valid, output out_channel, output average, input ready);
  modport sink   (input valid, input out_channel, input average, output ready);
endinterface

// ===== hw/rtl/mra_front.sv =====
// Front end: accepts requests, flags the channel range, holds a two-entry queue.
// Depends on mra_pkg and mra_req_if.
module mra_front #(
  parameter int unsigned CHANNELS = mra_pkg::DefChannels
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  mra_req_if.sink        req_i,
  output logic           item_valid_o,
  input  logic           item_ready_i,
  output mra_pkg::item_t item_o
);
  import mra_pkg::*;

  localparam logic [ChanW:0] ChanLimit = (ChanW + 1)'(CHANNELS);

  item_t      mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] fill_q;
  logic       push, pop;
  item_t      new_item;

  assign req_i.ready  = (fill_q != 2'd2);
  assign push         = req_i.valid && req_i.ready;
  assign item_valid_o = (fill_q != 2'd0);
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = mem_q[rptr_q];

  always_comb begin
    new_item.channel  = req_i.channel;
    new_item.sample   = req_i.sample;
    new_item.in_range = ({1'b0, req_i.channel} < ChanLimit);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= new_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      if (push && !pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/mra_back.sv =====
// Back end: per-channel state, sum/count update, radix-2 divider, result register.
// Depends on mra_pkg and mra_res_if.
module mra_back #(
  parameter int unsigned CHANNELS = mra_pkg::DefChannels
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     item_valid_i,
  output logic                     item_ready_o,
  input  mra_pkg::item_t           item_i,
  input  logic [mra_pkg::CntW-1:0] limit_i,
  mra_res_if.source                res_o
);
  import mra_pkg::*;

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  back_state_e st_q, st_d;

  logic [SumW-1:0] sum_mem_q [CHANNELS];
  logic [CntW-1:0] cnt_mem_q [CHANNELS];
  logic [AvgW-1:0] avg_mem_q [CHANNELS];

  logic [ChanW-1:0]   ch_q;
  logic [SampleW-1:0] smp_q;
  logic               inr_q;
  logic [SumW-1:0]    sum_q, dq_q;
  logic [CntW-1:0]    cnt_q, rem_q;
  logic [StepW-1:0]   step_q;
  logic [AvgW-1:0]    res_q;
  logic               div_q, wr_q;

  logic             ov_q;
  logic [ChanW-1:0] och_q;
  logic [AvgW-1:0]  oavg_q;

  logic            take, ld_en, div_en, fin_en, out_free, last_step;
  logic [IdxW-1:0] idx;
  logic [SumW-1:0] sum_inc, sum_new;
  logic [CntW:0]   cnt_inc, rem_sh, rem_sub;
  logic [CntW-1:0] cnt_new;
  logic            over, ge;
  logic [AvgW-1:0] quo_sat, avg_fin;

  assign idx       = ch_q[IdxW-1:0];
  assign out_free  = !ov_q || res_o.ready;
  assign last_step = (step_q == StepW'(DivSteps - 1));

  // state update
  always_comb begin
    sum_inc = sum_mem_q[idx] + SumW'(smp_q);
    cnt_inc = {1'b0, cnt_mem_q[idx]} + (CntW + 1)'(1);
    over    = (cnt_inc > {1'b0, limit_i});
    sum_new = over ? (sum_inc - SumW'(avg_mem_q[idx])) : sum_inc;
    cnt_new = over ? limit_i : cnt_inc[CntW-1:0];
  end

  // one restoring divide step
  always_comb begin
    rem_sh  = {rem_q, dq_q[SumW-1]};
    ge      = (rem_sh >= {1'b0, cnt_q});
    rem_sub = rem_sh - {1'b0, cnt_q};
    quo_sat = (|dq_q[SumW-1:AvgW]) ? {AvgW{1'b1}} : dq_q[AvgW-1:0];
    avg_fin = div_q ? quo_sat : res_q;
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (item_valid_i) st_d = StLoad;
      StLoad: st_d = (inr_q && (cnt_new != '0)) ? StDiv : StDone;
      StDiv:  if (last_step) st_d = StDone;
      StDone: if (out_free) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_comb begin
    item_ready_o = 1'b0;
    ld_en        = 1'b0;
    div_en       = 1'b0;
    fin_en       = 1'b0;
    unique case (st_q)
      StIdle:  item_ready_o = 1'b1;
      StLoad:  ld_en = 1'b1;
      StDiv:   div_en = 1'b1;
      StDone:  fin_en = out_free;
      default: ;
    endcase
  end

  assign take = item_valid_i && item_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (fin_en) begin
        ov_q <= 1'b1;
      end else if (res_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sum_mem_q[i] <= '0;
        cnt_mem_q[i] <= '0;
        avg_mem_q[i] <= '0;
      end
    end else if (fin_en && wr_q) begin
      sum_mem_q[idx] <= sum_q;
      cnt_mem_q[idx] <= cnt_q;
      avg_mem_q[idx] <= avg_fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      ch_q  <= item_i.channel;
      smp_q <= item_i.sample;
      inr_q <= item_i.in_range;
    end
    if (ld_en) begin
      sum_q  <= sum_new;
      cnt_q  <= cnt_new;
      dq_q   <= sum_new;
      rem_q  <= '0;
      step_q <= '0;
      res_q  <= inr_q ? avg_mem_q[idx] : '0;
      wr_q   <= inr_q;
      div_q  <= inr_q && (cnt_new != '0);
    end
    if (div_en) begin
      rem_q  <= ge ? rem_sub[CntW-1:0] : rem_sh[CntW-1:0];
      dq_q   <= {dq_q[SumW-2:0], ge};
      step_q <= step_q + StepW'(1);
    end
    if (fin_en) begin
      och_q  <= ch_q;
      oavg_q <= avg_fin;
    end
  end

  assign res_o.valid       = ov_q;
  assign res_o.out_channel = och_q;
  assign res_o.average     = oavg_q;

endmodule

// ===== hw/rtl/multichannel_running_average_core.sv =====
// Top level of the multichannel running average core: APB limit register,
// front-end queue and back-end update/divide. Depends on mra_pkg, mra_if, mra_front, mra_back.
//
//  port      dir   handshake        payload
//  req_i     in    valid/ready      channel, sample
//  res_o     out   valid/ready      out_channel, average
//  apb       in    psel/penable     window_limit at byte address 0
//
// A request passes through the back end as pop, update, 21 divide steps
// (one quotient bit each) and finish; only then does the back end take the next request.
// A channel out of range or a zero window limit skips the divide.
// The front queue takes two requests while the back end is busy.
// The result register holds its value while res_o.ready is low; the back end
// then waits in its finish step. Reset clears all channel state and sets the limit to 16.
module multichannel_running_average_core #(
  parameter int unsigned CHANNELS = mra_pkg::DefChannels
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  mra_req_if.sink                    req_i,
  mra_res_if.source                  res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mra_pkg::PAddrW-1:0] paddr,
  input  logic [mra_pkg::PDataW-1:0] pwdata,
  output logic [mra_pkg::PDataW-1:0] prdata,
  output logic                       pready
);
  import mra_pkg::*;

  logic [CntW-1:0] limit_q;
  logic            reg_hit;
  logic            item_valid, item_ready;
  item_t           item;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[PAddrW-1] == RegWindowLimit);
  assign prdata  = reg_hit ? PDataW'(limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      limit_q <= pwdata[CntW-1:0];
    end
  end

  mra_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .item_valid_o(item_valid),
    .item_ready_i(item_ready),
    .item_o      (item)
  );

  mra_back #(
    .CHANNELS(CHANNELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_valid),
    .item_ready_o(item_ready),
    .item_i      (item),
    .limit_i     (limit_q),
    .res_o       (res_o)
  );

endmodule

// ===== bench/tb_multichannel_running_average_core.sv =====
// Self-checking testbench for multichannel_running_average_core.
// Predicts every channel's running average, checks each result in order, paces both sides.
// Depends on mra_pkg, mra_if and the core RTL.
`timescale 1ns / 100ps

module tb_multichannel_running_average_core;
  import mra_pkg::*;

  localparam int unsigned NumChannels = DefChannels;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam logic [SumW-1:0] AvgMax  = SumW'((1 << SampleW) - 1);

  typedef struct packed {
    logic [ChanW-1:0] channel;
    logic [AvgW-1:0]  average;
  } avg_result_t;

  typedef enum int {
    PaceNone,
    PaceSendIdle,
    PaceRecvStall,
    PaceBoth
  } pace_e;

  logic clk;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PAddrW-1:0] paddr;
  logic [PDataW-1:0] pwdata;
  logic [PDataW-1:0] prdata;
  logic pready;

  mra_req_if req_bus ();
  mra_res_if res_bus ();

  multichannel_running_average_core dut (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .res_o  (res_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // predictor state
  logic [SumW-1:0] chan_sum   [NumChannels];
  logic [CntW-1:0] chan_count [NumChannels];
  logic [AvgW-1:0] chan_avg   [NumChannels];
  logic [CntW-1:0] window_limit_q;

  avg_result_t expected_avg_q[$];

  int send_idle_pct;
  int recv_stall_pct;
  int fail_count;
  int cycle_count;
  int request_count;
  int stray_request_count;
  int limit_write_count;
  int result_count;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic avg_result_t predict_average(input logic [ChanW-1:0] ch,
                                                  input logic [SampleW-1:0] smp);
    logic [SumW-1:0] sum;
    logic [CntW:0]   cnt;
    logic [AvgW-1:0] avg;
    logic [SumW-1:0] quo;
    avg_result_t     res;
    res.channel = ch;
    res.average = '0;
    if (ch < NumChannels) begin
      sum = chan_sum[ch] + SumW'(smp);
      cnt = {1'b0, chan_count[ch]} + 1'b1;
      avg = chan_avg[ch];
      if (cnt > {1'b0, window_limit_q}) begin
        cnt = {1'b0, window_limit_q};
        sum = sum - SumW'(avg);
      end
      if (cnt != '0) begin
        quo = sum / SumW'(cnt);
        avg = (quo > AvgMax) ? AvgMax[AvgW-1:0] : quo[AvgW-1:0];
      end
      chan_sum[ch]   = sum;
      chan_count[ch] = cnt[CntW-1:0];
      chan_avg[ch]   = avg;
      res.average    = avg;
    end
    return res;
  endfunction

  function automatic logic [ChanW-1:0] rand_channel(input int focus_pct, input int focus);
    int r;
    r = $urandom_range(99);
    if (r < 6) return ChanW'($urandom_range(15, NumChannels));
    if (r < 6 + focus_pct) return ChanW'(focus);
    return ChanW'($urandom_range(NumChannels - 1));
  endfunction

  function automatic logic [SampleW-1:0] rand_sample();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return SampleW'($urandom_range((1 << SampleW) - 1));
  endfunction

  task automatic set_pacing(input pace_e mode);
    case (mode)
      PaceNone: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      PaceSendIdle: begin
        send_idle_pct = 69;
        recv_stall_pct = 0;
      end
      PaceRecvStall: begin
        send_idle_pct = 0;
        recv_stall_pct = 69;
      end
      default: begin
        send_idle_pct = 35;
        recv_stall_pct = 35;
      end
    endcase
  endtask

  // called just after a falling edge
  task automatic send_sample(input logic [ChanW-1:0] ch, input logic [SampleW-1:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid = 1'b0;
      @(negedge clk);
    end
    req_bus.valid   = 1'b1;
    req_bus.channel = ch;
    req_bus.sample  = smp;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    expected_avg_q.push_back(predict_average(ch, smp));
    request_count++;
    if (ch >= NumChannels) stray_request_count++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    req_bus.valid = 1'b0;
    while (expected_avg_q.size() != 0) @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [PDataW-1:0] wdata,
                            output logic [PDataW-1:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = PAddrW'(4 * RegWindowLimit);
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_limit_readback();
    logic [PDataW-1:0] rdata;
    apb_access(1'b0, '0, rdata);
    if (rdata !== PDataW'(window_limit_q)) begin
      $error("window_limit: expected %0d, got %0d", window_limit_q, rdata);
      fail_count++;
    end
  endtask

  task automatic write_limit(input logic [CntW-1:0] value);
    logic [PDataW-1:0] rdata;
    drain_results();
    apb_access(1'b1, PDataW'(value), rdata);
    window_limit_q = value;
    limit_write_count++;
    check_limit_readback();
  endtask

  task automatic test_reset_state();
    check_limit_readback();
    set_pacing(PaceNone);
    send_sample(4'd0, '0);
    send_sample(4'd8, '1);
    send_sample(4'd9, '1);
    send_sample(4'd15, '0);
    send_sample(4'd15, '1);
    for (int ch = 1; ch < 8; ch++) begin
      send_sample(ChanW'(ch), (ch % 2) ? 10'h155 : 10'h2AA);
    end
  endtask

  task automatic test_limit_lowered();
    write_limit(CntW'(1023));
    repeat (5) send_sample(4'd4, '1);
    write_limit(CntW'(2));
    send_sample(4'd4, 10'd17);
  endtask

  task automatic test_limit_zero();
    write_limit('0);
    repeat (3) send_sample(4'd6, 10'd5);
    write_limit(CntW'(1));
    send_sample(4'd6, '1);
    send_sample(4'd6, '0);
  endtask

  // one channel takes most requests so its count reaches the top
  task automatic test_count_saturation();
    write_limit(CntW'(1023));
    for (int i = 0; i < 1200; i++) begin
      if (i % 40 == 0) set_pacing(pace_e'((i / 40) % 4));
      send_sample(rand_channel(88, 5), rand_sample());
    end
  endtask

  task automatic test_random_limits();
    logic [CntW-1:0] lim;
    for (int seg = 0; seg < 10; seg++) begin
      case (seg)
        0: lim = CntW'(1);
        1: lim = '0;
        2: lim = '1;
        default: begin
          case ($urandom_range(4))
            0: lim = '0;
            1: lim = '1;
            2: lim = CntW'($urandom_range(1, 8));
            default: lim = CntW'($urandom_range(9, 1022));
          endcase
        end
      endcase
      write_limit(lim);
      for (int i = 0; i < 50; i++) begin
        if (i % 25 == 0) set_pacing(pace_e'($urandom_range(3)));
        send_sample(rand_channel(0, 0), rand_sample());
      end
    end
  endtask

  always @(negedge clk) begin
    res_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    avg_result_t exp_res;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      result_count++;
      if (expected_avg_q.size() == 0) begin
        $error("unexpected result: out_channel %0d, average %0d",
               res_bus.out_channel, res_bus.average);
        fail_count++;
      end else begin
        exp_res = expected_avg_q.pop_front();
        if (res_bus.out_channel !== exp_res.channel) begin
          $error("out_channel: expected %0d, got %0d", exp_res.channel, res_bus.out_channel);
          fail_count++;
        end
        if (res_bus.average !== exp_res.average) begin
          $error("average: expected %0d, got %0d", exp_res.average, res_bus.average);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $error("timeout after %0d cycles, %0d results pending", cycle_count,
             expected_avg_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    req_bus.valid   = 1'b0;
    req_bus.channel = '0;
    req_bus.sample  = '0;
    res_bus.ready   = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    fail_count      = 0;
    cycle_count     = 0;
    request_count   = 0;
    stray_request_count = 0;
    limit_write_count   = 0;
    result_count    = 0;
    window_limit_q  = LimitReset;
    for (int ch = 0; ch < NumChannels; ch++) begin
      chan_sum[ch]   = '0;
      chan_count[ch] = '0;
      chan_avg[ch]   = '0;
    end
    repeat (9) @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    test_reset_state();
    test_limit_lowered();
    test_limit_zero();
    test_count_saturation();
    test_random_limits();

    drain_results();
    repeat (40) @(posedge clk);

    $display("Run covered %0d requests (%0d on channels out of range), %0d results checked,",
             request_count, stray_request_count, result_count);
    $display("%0d window limit writes incl. 0 and 1023, under four pacing modes.",
             limit_write_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== multichannel_running_average_core.f =====
hw/rtl/mra_pkg.sv
hw/rtl/mra_if.sv
hw/rtl/mra_front.sv
hw/rtl/mra_back.sv
hw/rtl/multichannel_running_average_core.sv
bench/tb_multichannel_running_average_core.sv
